### hdl/assert_macros.svh
// Assertion macros used by the receiver top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

### hdl/bfrc8_pkg.sv
// Shared types, constants and CRC helpers for the frame receiver.
package bfrc8_pkg;

  localparam logic [7:0] OWN_ADDRESS_RESET = 8'h02;
  localparam logic [7:0] HEADER_BYTE_RESET = 8'hFE;
  localparam logic [7:0] CRC_POLY          = 8'h31;
  localparam logic [7:0] CMD_UPDATE        = 8'h18;
  localparam logic [7:0] CMD_PLAIN_FIRST   = 8'h01;
  localparam logic [7:0] CMD_PLAIN_LAST    = 8'h09;
  localparam logic [7:0] INDEX_BYTE_FOUR   = 8'd4;
  localparam logic [7:0] INDEX_BYTE_FIVE   = 8'd5;
  localparam logic [7:0] INDEX_DEST        = 8'd1;
  localparam logic [7:0] INDEX_SOURCE      = 8'd2;
  localparam logic [7:0] INDEX_COMMAND     = 8'd3;

  // Register select: bit 2 of the byte address.
  localparam logic REG_OWN_ADDRESS = 1'b0;
  localparam logic REG_HEADER_BYTE = 1'b1;

  localparam int CMD_W = 5;

  // One finished frame, handed from the parser to the result stage.
  typedef struct packed {
    logic [7:0] check_byte;
    logic [7:0] dest;
    logic [7:0] source;
    logic [7:0] command;
    logic [7:0] crc;
    logic [7:0] byte_four;
    logic [7:0] byte_five;
  } frame_rec_t;

  // CRC-8, poly 0x31, MSB first, one byte folded in.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] x;
    x = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (x[7]) begin
        x = {x[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        x = {x[6:0], 1'b0};
      end
    end
    return x;
  endfunction

  function automatic logic [CMD_W-1:0] decode_command(input logic [7:0] c);
    if ((c >= CMD_PLAIN_FIRST && c <= CMD_PLAIN_LAST) || c == CMD_UPDATE) begin
      return c[CMD_W-1:0];
    end
    return '0;
  endfunction

endpackage

### hdl/bfrc8_front.sv
// Byte parser: hunts for the header, tracks frame fields and the running CRC.
module bfrc8_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_ready,
  input  logic [7:0]            rx_byte,
  input  logic [7:0]            header_byte,
  input  logic                  queue_full,
  output logic                  rec_push,
  output bfrc8_pkg::frame_rec_t rec
);

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_LENGTH  = 3'd1;
  localparam logic [2:0] PH_DEST    = 3'd2;
  localparam logic [2:0] PH_SOURCE  = 3'd3;
  localparam logic [2:0] PH_COMMAND = 3'd4;
  localparam logic [2:0] PH_DATA    = 3'd5;

  logic [2:0] phase, phase_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] byte_index, byte_index_next;
  logic [7:0] crc_accum, crc_accum_next;
  logic [7:0] dest_seen, dest_seen_next;
  logic [7:0] source_seen, source_seen_next;
  logic [7:0] command_seen, command_seen_next;
  logic [7:0] byte_four, byte_four_next;
  logic [7:0] byte_five, byte_five_next;
  logic [7:0] index_inc;
  logic       accept;
  logic       frame_end;

  assign byte_ready = !queue_full;
  assign accept     = byte_valid && byte_ready;
  assign index_inc  = byte_index + 8'd1;

  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    byte_index_next   = byte_index;
    crc_accum_next    = crc_accum;
    dest_seen_next    = dest_seen;
    source_seen_next  = source_seen;
    command_seen_next = command_seen;
    byte_four_next    = byte_four;
    byte_five_next    = byte_five;
    frame_end         = 1'b0;
    case (phase)
      PH_HUNT: begin
        if (rx_byte == header_byte) begin
          phase_next = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        frame_length_next = rx_byte;
        byte_index_next   = 8'd0;
        crc_accum_next    = (rx_byte != 8'd0) ? bfrc8_pkg::crc8_update(8'd0, rx_byte) : 8'd0;
        phase_next        = PH_DEST;
      end
      PH_DEST: begin
        byte_index_next = bfrc8_pkg::INDEX_DEST;
        dest_seen_next  = rx_byte;
        if (bfrc8_pkg::INDEX_DEST < frame_length) begin
          crc_accum_next = bfrc8_pkg::crc8_update(crc_accum, rx_byte);
        end
        phase_next = PH_SOURCE;
      end
      PH_SOURCE: begin
        byte_index_next  = bfrc8_pkg::INDEX_SOURCE;
        source_seen_next = rx_byte;
        if (bfrc8_pkg::INDEX_SOURCE < frame_length) begin
          crc_accum_next = bfrc8_pkg::crc8_update(crc_accum, rx_byte);
        end
        phase_next = PH_COMMAND;
      end
      PH_COMMAND: begin
        byte_index_next   = bfrc8_pkg::INDEX_COMMAND;
        command_seen_next = rx_byte;
        if (bfrc8_pkg::INDEX_COMMAND < frame_length) begin
          crc_accum_next = bfrc8_pkg::crc8_update(crc_accum, rx_byte);
        end
        phase_next = PH_DATA;
      end
      PH_DATA: begin
        byte_index_next = index_inc;
        if (index_inc == bfrc8_pkg::INDEX_BYTE_FOUR) begin
          byte_four_next = rx_byte;
        end else if (index_inc == bfrc8_pkg::INDEX_BYTE_FIVE) begin
          byte_five_next = rx_byte;
        end
        if (index_inc < frame_length) begin
          crc_accum_next = bfrc8_pkg::crc8_update(crc_accum, rx_byte);
        end else begin
          // check byte: close the frame
          frame_end  = 1'b1;
          phase_next = PH_HUNT;
        end
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  assign rec_push       = accept && frame_end;
  assign rec.check_byte = rx_byte;
  assign rec.dest       = dest_seen;
  assign rec.source     = source_seen;
  assign rec.command    = command_seen;
  assign rec.crc        = crc_accum;
  assign rec.byte_four  = byte_four_next;
  assign rec.byte_five  = byte_five_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      frame_length <= 8'd0;
      byte_index   <= 8'd0;
      crc_accum    <= 8'd0;
      dest_seen    <= 8'd0;
      source_seen  <= 8'd0;
      command_seen <= 8'd0;
      byte_four    <= 8'd0;
      byte_five    <= 8'd0;
    end else if (accept) begin
      phase        <= phase_next;
      frame_length <= frame_length_next;
      byte_index   <= byte_index_next;
      crc_accum    <= crc_accum_next;
      dest_seen    <= dest_seen_next;
      source_seen  <= source_seen_next;
      command_seen <= command_seen_next;
      byte_four    <= byte_four_next;
      byte_five    <= byte_five_next;
    end
  end

endmodule

### hdl/bfrc8_queue.sv
// Short queue of finished frame records between the parser and the result stage.
module bfrc8_queue #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  bfrc8_pkg::frame_rec_t push_rec,
  output logic                  full,
  input  logic                  pop,
  output logic                  not_empty,
  output bfrc8_pkg::frame_rec_t head_rec
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bfrc8_pkg::frame_rec_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head_rec  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### hdl/bfrc8_back.sv
// Result stage: judges each frame, updates the held sequence and status, registers the beat.
module bfrc8_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rec_valid,
  input  bfrc8_pkg::frame_rec_t       rec,
  output logic                        rec_pop,
  input  logic [7:0]                  own_address,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        frame_good,
  output logic [bfrc8_pkg::CMD_W-1:0] command_code,
  output logic [7:0]                  source_address,
  output logic [7:0]                  dest_address,
  output logic [7:0]                  update_sequence,
  output logic [7:0]                  update_status,
  output logic [7:0]                  crc_computed
);

  logic                        good;
  logic [bfrc8_pkg::CMD_W-1:0] cmd;
  logic                        do_update;
  logic [7:0]                  held_sequence, held_sequence_next;
  logic [7:0]                  held_status, held_status_next;

  assign rec_pop   = rec_valid && (!out_valid || out_ready);
  assign good      = (rec.dest == own_address) && (rec.check_byte == rec.crc);
  assign cmd       = good ? bfrc8_pkg::decode_command(rec.command) : '0;
  assign do_update = good && (rec.command == bfrc8_pkg::CMD_UPDATE);

  assign held_sequence_next = do_update ? rec.byte_four : held_sequence;
  assign held_status_next   = do_update ? rec.byte_five : held_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      held_sequence <= 8'd0;
      held_status   <= 8'd0;
    end else begin
      if (rec_pop) begin
        out_valid     <= 1'b1;
        held_sequence <= held_sequence_next;
        held_status   <= held_status_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      frame_good      <= good;
      command_code    <= cmd;
      source_address  <= rec.source;
      dest_address    <= rec.dest;
      update_sequence <= held_sequence_next;
      update_status   <= held_status_next;
      crc_computed    <= rec.crc;
    end
  end

endmodule

### hdl/bus_frame_receiver_crc8_unit.sv
// Top level of the length-prefixed bus frame receiver with CRC-8 check.
// Bus bytes enter one per beat on the slave stream. The parser hunts for the
// header byte, then takes length, destination, source and command, then data;
// the byte at index max(length, 4) is the check byte and closes the frame.
// The CRC-8 (poly 0x31, init 0) covers indices 0 to length-1. Each closed frame
// yields one result beat: the good flag on tuser, and on tdata the decoded
// command (1-9 or 0x18 on a good frame, else 0), source and destination, the
// held update sequence and status (loaded from frame bytes four and five by a
// good 0x18 frame) and the computed CRC. A byte is taken every cycle: the
// parser folds one byte into the CRC per cycle, and a queue of QUEUE_DEPTH
// frame records parts it from the output register, so the input stalls only
// when that queue is full because the master side is holding results back.
// When nothing is waiting, a check byte's record is registered in the queue, then in the output register.
// Configuration sits on the APB port: own address at 0x0, header byte at 0x4;
// write them only while no frame is in progress and no result is pending.
module bus_frame_receiver_crc8_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // slave stream: rx_byte [7:0]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // command_code [4:0], source_address [12:5], dest_address [20:13],
  // update_sequence [28:21], update_status [36:29], crc_computed [44:37], zero [47:45]
  output logic [47:0] m_tdata,
  // frame_good [0]
  output logic        m_tuser,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

`include "assert_macros.svh"

  logic [7:0] own_address;
  logic [7:0] header_byte;
  logic       cfg_write;

  bfrc8_pkg::frame_rec_t push_rec;
  bfrc8_pkg::frame_rec_t head_rec;
  logic                  rec_push;
  logic                  rec_pop;
  logic                  queue_full;
  logic                  queue_not_empty;

  logic [bfrc8_pkg::CMD_W-1:0] command_code;
  logic [7:0] source_address;
  logic [7:0] dest_address;
  logic [7:0] update_sequence;
  logic [7:0] update_status;
  logic [7:0] crc_computed;

  // Configuration registers; bit 2 of the address picks the register.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= bfrc8_pkg::OWN_ADDRESS_RESET;
      header_byte <= bfrc8_pkg::HEADER_BYTE_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        bfrc8_pkg::REG_OWN_ADDRESS: own_address <= pwdata[7:0];
        bfrc8_pkg::REG_HEADER_BYTE: header_byte <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      bfrc8_pkg::REG_OWN_ADDRESS: prdata = {24'd0, own_address};
      bfrc8_pkg::REG_HEADER_BYTE: prdata = {24'd0, header_byte};
      default:                    prdata = 32'd0;
    endcase
  end

  // Front: parse bytes, push one record per closed frame.
  bfrc8_front u_front (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (s_tvalid),
    .byte_ready  (s_tready),
    .rx_byte     (s_tdata),
    .header_byte (header_byte),
    .queue_full  (queue_full),
    .rec_push    (rec_push),
    .rec         (push_rec)
  );

  // Hold finished frames while the output side stalls.
  bfrc8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (rec_push),
    .push_rec  (push_rec),
    .full      (queue_full),
    .pop       (rec_pop),
    .not_empty (queue_not_empty),
    .head_rec  (head_rec)
  );

  // Back: judge the frame and register the result beat.
  bfrc8_back u_back (
    .clk             (clk),
    .rst             (rst),
    .rec_valid       (queue_not_empty),
    .rec             (head_rec),
    .rec_pop         (rec_pop),
    .own_address     (own_address),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .frame_good      (m_tuser),
    .command_code    (command_code),
    .source_address  (source_address),
    .dest_address    (dest_address),
    .update_sequence (update_sequence),
    .update_status   (update_status),
    .crc_computed    (crc_computed)
  );

  assign m_tdata = {3'd0, crc_computed, update_status, update_sequence,
                    dest_address, source_address, command_code};

  // A good frame was addressed to this node.
  `ASSERT_IMPLIES(good_frame_addr_a, clk, rst, m_tvalid && m_tuser, dest_address == own_address)
  // Bad frames never carry a command.
  `ASSERT_IMPLIES(bad_frame_cmd_a, clk, rst, m_tvalid && !m_tuser, command_code == '0)
  // A record taken from the queue is shown on the master side next cycle.
  `ASSERT_NEXT(pop_to_out_a, clk, rst, rec_pop, m_tvalid)
  // The parser never pushes into a full queue.
  `ASSERT_IMPLIES(no_push_when_full_a, clk, rst, queue_full, !rec_push)

endmodule
